FILE: rtl/assert_macros.svh
// Assertion macros used by the checker file of the limiter.
// Each macro expands to one labeled concurrent assertion that reports by $error.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A condition that holds at every clock edge outside reset.
`define APL_ASSERT_ALWAYS(lbl, clk, rstn, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (cond)) \
    else $error(msg);

// When the antecedent holds, the consequent holds at the next clock edge.
`define APL_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/apl_pkg.sv
// Shared types and constants of the audio peak limiter.
// No dependencies; every other file of the limiter but assert_macros.svh imports this package.
`timescale 1ns / 1ps

package apl_pkg;

  // Number formats.
  localparam int SAMPLE_FRAC_BITS = 20;
  localparam int GAIN_FRAC_BITS   = 23;
  localparam int MASTER_FRAC_BITS = 16;

  localparam int SAMPLE_W   = 32;
  localparam int GAIN_W     = GAIN_FRAC_BITS + 1;
  localparam int STEP_W     = 24;
  localparam int MASTER_W   = 26;
  localparam int CHAN_CNT_W = 2;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 26;

  localparam logic [GAIN_W-1:0]   GAIN_ONE      = {1'b1, {GAIN_FRAC_BITS{1'b0}}};
  localparam logic [MASTER_W-1:0] SILENT_MASTER = MASTER_W'(65);

  // The smallest master gain that is not silent is above 2^6, which bounds
  // the ceiling quotient. A silent master gives 1000.0, below 2^10.
  localparam int MASTER_MIN_LOG2 = 6;
  localparam int CEIL_DIV_STEPS  = SAMPLE_FRAC_BITS + MASTER_FRAC_BITS - MASTER_MIN_LOG2;
  localparam int CEIL_W          = SAMPLE_FRAC_BITS + 10;

  localparam logic [CEIL_W-1:0] CEIL_UNITY  = CEIL_W'(1) << SAMPLE_FRAC_BITS;
  localparam logic [CEIL_W-1:0] CEIL_SILENT = CEIL_W'(1000) << SAMPLE_FRAC_BITS;

  // Shared shift-subtract divider.
  localparam int DIV_W      = SAMPLE_W;
  localparam int DIV_TAIL_W = (CEIL_DIV_STEPS > GAIN_W) ? CEIL_DIV_STEPS : GAIN_W;
  localparam int DIV_CNT_W  = $clog2(DIV_TAIL_W + 1);

  localparam logic [DIV_W-1:0] CEIL_REM_INIT =
    DIV_W'(1) << (SAMPLE_FRAC_BITS + MASTER_FRAC_BITS - CEIL_DIV_STEPS);

  localparam int PROD_W = SAMPLE_W + GAIN_W + 1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ENABLE         = 3'd0,
    REG_EXTENDED_RANGE = 3'd1,
    REG_MASTER_GAIN    = 3'd2,
    REG_CHANNEL_COUNT  = 3'd3,
    REG_ATTACK_STEP    = 3'd4,
    REG_RELEASE_STEP   = 3'd5
  } cfg_reg_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PEAK,
    ST_CMP,
    ST_DIV,
    ST_UPDATE,
    ST_MUL,
    ST_WRITE,
    ST_CEIL_START,
    ST_CEIL_WAIT
  } apl_state_e;

  typedef struct packed {
    logic cfg_we;
    logic capture;
    logic peak;
    logic div_frame;
    logic div_ceil;
    logic ceil_load;
    logic gain_update;
    logic mult;
    logic out_load;
  } apl_cmd_t;

  typedef struct packed {
    logic enable;
    logic over;
    logic div_busy;
    logic out_free;
  } apl_sts_t;

endpackage

FILE: rtl/apl_div.sv
// Restoring shift-subtract divider, one quotient bit per cycle.
// Depends on apl_pkg for its widths.
`timescale 1ns / 1ps

module apl_div (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [apl_pkg::DIV_W-1:0]     divisor_i,
  input  logic [apl_pkg::DIV_W-1:0]     rem_init_i,
  input  logic [apl_pkg::DIV_TAIL_W-1:0] tail_i,
  input  logic [apl_pkg::DIV_CNT_W-1:0] steps_i,
  output logic                          busy_o,
  output logic [apl_pkg::DIV_TAIL_W-1:0] quot_o
);
  import apl_pkg::*;

  logic                  busy_q, busy_d;
  logic [DIV_CNT_W-1:0]  cnt_q, cnt_d;
  logic [DIV_W-1:0]      rem_q, rem_d;
  logic [DIV_W-1:0]      dvs_q, dvs_d;
  logic [DIV_TAIL_W-1:0] tail_q, tail_d;
  logic [DIV_TAIL_W-1:0] quot_q, quot_d;
  logic [DIV_W:0]        rem_sh;
  logic                  fits;

  // The remainder stays below the divisor, so the shifted value needs one extra bit.
  assign rem_sh = {rem_q, tail_q[DIV_TAIL_W-1]};
  assign fits   = rem_sh >= {1'b0, dvs_q};

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    tail_d = tail_q;
    quot_d = quot_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = steps_i;
      rem_d  = rem_init_i;
      dvs_d  = divisor_i;
      tail_d = tail_i;
      quot_d = '0;
    end else if (busy_q) begin
      rem_d  = fits ? DIV_W'(rem_sh - {1'b0, dvs_q}) : rem_sh[DIV_W-1:0];
      tail_d = {tail_q[DIV_TAIL_W-2:0], 1'b0};
      quot_d = {quot_q[DIV_TAIL_W-2:0], fits};
      cnt_d  = cnt_q - DIV_CNT_W'(1);
      if (cnt_q == DIV_CNT_W'(1)) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    dvs_q  <= dvs_d;
    tail_q <= tail_d;
    quot_q <= quot_d;
  end

  assign busy_o = busy_q;
  assign quot_o = quot_q;

endmodule

FILE: rtl/apl_ctrl.sv
// Sequencing state machine of the limiter: handshakes and datapath commands.
// Depends on apl_pkg for the state, command and status types.
`timescale 1ns / 1ps

module apl_ctrl (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic                         cfg_valid_i,
  input  logic [apl_pkg::CFG_IDX_W-1:0] cfg_index_i,
  output logic                         cfg_ready_o,
  input  apl_pkg::apl_sts_t            sts_i,
  output apl_pkg::apl_cmd_t            cmd_o
);
  import apl_pkg::*;

  apl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    cfg_ready_o = 1'b0;
    // A pending configuration request takes priority over a frame.
    in_stall_o  = (state_q != ST_IDLE) || cfg_valid_i;
    unique case (state_q)
      ST_IDLE: begin
        cfg_ready_o = 1'b1;
        if (cfg_valid_i) begin
          cmd_o.cfg_we = 1'b1;
          if (cfg_reg_e'(cfg_index_i) == REG_MASTER_GAIN) begin
            state_d = ST_CEIL_START;
          end
        end else if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d = sts_i.enable ? ST_PEAK : ST_WRITE;
        end
      end
      ST_PEAK: begin
        cmd_o.peak = 1'b1;
        state_d = ST_CMP;
      end
      ST_CMP: begin
        if (sts_i.over) begin
          cmd_o.div_frame = 1'b1;
          state_d = ST_DIV;
        end else begin
          state_d = ST_UPDATE;
        end
      end
      ST_DIV: begin
        if (!sts_i.div_busy) begin
          state_d = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        cmd_o.gain_update = 1'b1;
        state_d = ST_MUL;
      end
      ST_MUL: begin
        cmd_o.mult = 1'b1;
        state_d = ST_WRITE;
      end
      ST_WRITE: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d = ST_IDLE;
        end
      end
      ST_CEIL_START: begin
        cmd_o.div_ceil = 1'b1;
        state_d = ST_CEIL_WAIT;
      end
      ST_CEIL_WAIT: begin
        if (!sts_i.div_busy) begin
          cmd_o.ceil_load = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

FILE: rtl/apl_dp.sv
// Datapath of the limiter: registers, peak, gain tracking, scaling, output stage.
// Depends on apl_pkg and instantiates apl_div.
`timescale 1ns / 1ps

module apl_dp (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  apl_pkg::apl_cmd_t              cmd_i,
  output apl_pkg::apl_sts_t              sts_o,
  input  logic [apl_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [apl_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic signed [apl_pkg::SAMPLE_W-1:0] sample_a_i,
  input  logic signed [apl_pkg::SAMPLE_W-1:0] sample_b_i,
  input  logic                           bad_a_i,
  input  logic                           bad_b_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic signed [apl_pkg::SAMPLE_W-1:0] out_a_o,
  output logic signed [apl_pkg::SAMPLE_W-1:0] out_b_o,
  output logic [apl_pkg::GAIN_W-1:0]     applied_gain_o
);
  import apl_pkg::*;

  localparam logic signed [PROD_W-1:0] ROUND_HALF = PROD_W'(1) << (GAIN_FRAC_BITS - 1);
  localparam logic signed [PROD_W-1:0] SAT_MAX =
    {{(PROD_W-SAMPLE_W+1){1'b0}}, {(SAMPLE_W-1){1'b1}}};
  localparam logic signed [PROD_W-1:0] SAT_MIN =
    {{(PROD_W-SAMPLE_W+1){1'b1}}, {(SAMPLE_W-1){1'b0}}};

  // Round to nearest with ties up, then saturate to the sample range.
  function automatic logic [SAMPLE_W-1:0] round_sat(input logic signed [PROD_W-1:0] p);
    logic signed [PROD_W-1:0] r;
    r = (p + ROUND_HALF) >>> GAIN_FRAC_BITS;
    if (r > SAT_MAX) begin
      return SAT_MAX[SAMPLE_W-1:0];
    end else if (r < SAT_MIN) begin
      return SAT_MIN[SAMPLE_W-1:0];
    end
    return r[SAMPLE_W-1:0];
  endfunction

  // Configuration registers.
  logic                  enable_q;
  logic                  ext_q;
  logic [MASTER_W-1:0]   master_q;
  logic [CHAN_CNT_W-1:0] chan_q;
  logic [STEP_W-1:0]     attack_q;
  logic [STEP_W-1:0]     release_q;
  logic [CEIL_W-1:0]     ceil_q;

  // Gain state.
  logic [GAIN_W-1:0] cur_q, cur_d;
  logic [GAIN_W-1:0] tgt_q, tgt_d;

  // Frame registers.
  logic signed [SAMPLE_W-1:0] sa_q, sb_q;
  logic                       bad_a_q, bad_b_q;
  logic [SAMPLE_W-1:0]        peak_q, peak_d;
  logic signed [PROD_W-1:0]   prod_a_q, prod_b_q, prod_a_d, prod_b_d;

  // Output stage.
  logic                       out_valid_q;
  logic signed [SAMPLE_W-1:0] out_a_q, out_b_q, out_a_d, out_b_d;
  logic [GAIN_W-1:0]          gain_out_q, gain_out_d;

  logic                  stereo;
  logic [CEIL_W-1:0]     ceil_sel;
  logic                  over;
  logic [SAMPLE_W-1:0]   abs_a, abs_b, mag_a, mag_b;

  logic                   div_start;
  logic [DIV_W-1:0]       div_divisor, div_rem;
  logic [DIV_TAIL_W-1:0]  div_tail, div_quot;
  logic [DIV_CNT_W-1:0]   div_steps;
  logic                   div_busy;

  logic [GAIN_W-1:0] quot_g;
  logic [GAIN_W:0]   tgt_sum, cur_sum;
  logic [GAIN_W-1:0] cur_diff;

  assign stereo = chan_q[1];

  always_comb begin
    if (!ext_q) begin
      ceil_sel = CEIL_UNITY;
    end else if (master_q <= SILENT_MASTER) begin
      ceil_sel = CEIL_SILENT;
    end else begin
      ceil_sel = ceil_q;
    end
  end

  // Peak over the good channels; the magnitude of the most negative sample fits unsigned.
  assign abs_a  = sa_q[SAMPLE_W-1] ? SAMPLE_W'(-sa_q) : sa_q;
  assign abs_b  = sb_q[SAMPLE_W-1] ? SAMPLE_W'(-sb_q) : sb_q;
  assign mag_a  = bad_a_q ? '0 : abs_a;
  assign mag_b  = (!stereo || bad_b_q) ? '0 : abs_b;
  assign peak_d = (mag_b > mag_a) ? mag_b : mag_a;
  assign over   = peak_q > SAMPLE_W'(ceil_sel);

  // Both divisions start with the part of the dividend that is known to be
  // below the divisor, then shift in the remaining dividend bits.
  always_comb begin
    div_start   = cmd_i.div_frame || cmd_i.div_ceil;
    div_divisor = peak_q;
    div_rem     = DIV_W'(ceil_sel >> 1);
    div_tail    = {ceil_sel[0], {(DIV_TAIL_W-1){1'b0}}};
    div_steps   = DIV_CNT_W'(GAIN_W);
    if (cmd_i.div_ceil) begin
      div_divisor = DIV_W'(master_q);
      div_rem     = CEIL_REM_INIT;
      div_tail    = '0;
      div_steps   = DIV_CNT_W'(CEIL_DIV_STEPS);
    end
  end

  apl_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .divisor_i  (div_divisor),
    .rem_init_i (div_rem),
    .tail_i     (div_tail),
    .steps_i    (div_steps),
    .busy_o     (div_busy),
    .quot_o     (div_quot)
  );

  // Target and current gain for this frame.
  assign quot_g  = div_quot[GAIN_W-1:0];
  assign tgt_sum = {1'b0, tgt_q} + {1'b0, release_q};

  always_comb begin
    if (over) begin
      tgt_d = (quot_g < tgt_q) ? quot_g : tgt_q;
    end else if (tgt_q < GAIN_ONE) begin
      tgt_d = (tgt_sum > {1'b0, GAIN_ONE}) ? GAIN_ONE : tgt_sum[GAIN_W-1:0];
    end else begin
      tgt_d = tgt_q;
    end
  end

  assign cur_diff = cur_q - tgt_d;
  assign cur_sum  = {1'b0, cur_q} + {1'b0, release_q};

  always_comb begin
    if (cur_q > tgt_d) begin
      cur_d = (cur_diff <= attack_q) ? tgt_d : cur_q - attack_q;
    end else if (cur_q < tgt_d) begin
      cur_d = (cur_sum > {1'b0, tgt_d}) ? tgt_d : cur_sum[GAIN_W-1:0];
    end else begin
      cur_d = cur_q;
    end
  end

  assign prod_a_d = $signed(sa_q) * $signed({1'b0, cur_q});
  assign prod_b_d = $signed(sb_q) * $signed({1'b0, cur_q});

  always_comb begin
    if (!enable_q) begin
      out_a_d    = sa_q;
      out_b_d    = stereo ? sb_q : '0;
      gain_out_d = GAIN_ONE;
    end else begin
      out_a_d    = bad_a_q ? '0 : round_sat(prod_a_q);
      out_b_d    = (!stereo || bad_b_q) ? '0 : round_sat(prod_b_q);
      gain_out_d = cur_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_q    <= 1'b0;
      ext_q       <= 1'b0;
      master_q    <= MASTER_W'(65536);
      chan_q      <= CHAN_CNT_W'(2);
      attack_q    <= STEP_W'(65536);
      release_q   <= STEP_W'(1024);
      ceil_q      <= CEIL_UNITY;
      cur_q       <= GAIN_ONE;
      tgt_q       <= GAIN_ONE;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.cfg_we) begin
        unique case (cfg_reg_e'(cfg_index_i))
          REG_ENABLE: begin
            enable_q <= cfg_data_i[0];
            cur_q    <= GAIN_ONE;
            tgt_q    <= GAIN_ONE;
          end
          REG_EXTENDED_RANGE: ext_q     <= cfg_data_i[0];
          REG_MASTER_GAIN:    master_q  <= cfg_data_i[MASTER_W-1:0];
          REG_CHANNEL_COUNT:  chan_q    <= cfg_data_i[CHAN_CNT_W-1:0];
          REG_ATTACK_STEP:    attack_q  <= cfg_data_i[STEP_W-1:0];
          REG_RELEASE_STEP:   release_q <= cfg_data_i[STEP_W-1:0];
          default: begin
          end
        endcase
      end
      if (cmd_i.ceil_load) begin
        ceil_q <= CEIL_W'(div_quot);
      end
      if (cmd_i.gain_update) begin
        cur_q <= cur_d;
        tgt_q <= tgt_d;
      end
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      sa_q    <= sample_a_i;
      sb_q    <= sample_b_i;
      bad_a_q <= bad_a_i;
      bad_b_q <= bad_b_i;
    end
    if (cmd_i.peak) begin
      peak_q <= peak_d;
    end
    if (cmd_i.mult) begin
      prod_a_q <= prod_a_d;
      prod_b_q <= prod_b_d;
    end
    if (cmd_i.out_load) begin
      out_a_q    <= out_a_d;
      out_b_q    <= out_b_d;
      gain_out_q <= gain_out_d;
    end
  end

  assign sts_o.enable   = enable_q;
  assign sts_o.over     = over;
  assign sts_o.div_busy = div_busy;
  assign sts_o.out_free = !out_valid_q || !out_stall_i;

  assign out_valid_o    = out_valid_q;
  assign out_a_o        = out_a_q;
  assign out_b_o        = out_b_q;
  assign applied_gain_o = gain_out_q;

endmodule

FILE: rtl/audio_peak_limiter.sv
// Peak limiter for frames of one or two Q12.20 samples with a Q1.23 gain that
// falls by the attack step and recovers by the release step. It works on one
// frame at a time. When the limiter is disabled, a frame goes from capture
// straight to the output register; when enabled, it passes the peak, compare,
// update and multiply steps, and when it overloads, the compare step also starts
// the shared shift-subtract divider, which forms ceiling/peak at one quotient bit
// per cycle (24 bits). The next frame is accepted in the cycle after the result
// is loaded at the earliest. The result waits in an output register, so the next
// frame is taken while it is still stalled. A write of master_gain recomputes the
// extended ceiling in the same divider, during which no frame is accepted.
// Depends on apl_pkg, apl_ctrl and apl_dp.
`timescale 1ns / 1ps

module audio_peak_limiter (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic signed [apl_pkg::SAMPLE_W-1:0] sample_a_i,
  input  logic signed [apl_pkg::SAMPLE_W-1:0] sample_b_i,
  input  logic                                bad_a_i,
  input  logic                                bad_b_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic signed [apl_pkg::SAMPLE_W-1:0] out_a_o,
  output logic signed [apl_pkg::SAMPLE_W-1:0] out_b_o,
  output logic [apl_pkg::GAIN_W-1:0]          applied_gain_o,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [apl_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [apl_pkg::CFG_DATA_W-1:0]      cfg_data_i
);
  import apl_pkg::*;

  apl_cmd_t cmd;
  apl_sts_t sts;

  apl_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_ready_o (cfg_ready_o),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  apl_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .sample_a_i     (sample_a_i),
    .sample_b_i     (sample_b_i),
    .bad_a_i        (bad_a_i),
    .bad_b_i        (bad_b_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .out_a_o        (out_a_o),
    .out_b_o        (out_b_o),
    .applied_gain_o (applied_gain_o)
  );

endmodule

FILE: rtl/apl_checker.sv
// Port-level checks of the limiter, attached to the top level by bind.
// Depends on apl_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module apl_checker (
  input logic                                clk_i,
  input logic                                rst_ni,
  input logic                                in_valid_i,
  input logic                                in_stall_o,
  input logic                                out_valid_o,
  input logic                                out_stall_i,
  input logic signed [apl_pkg::SAMPLE_W-1:0] out_a_o,
  input logic [apl_pkg::GAIN_W-1:0]          applied_gain_o,
  input logic                                cfg_valid_i
);
  import apl_pkg::*;

  // The gain never rises above unity.
  `APL_ASSERT_ALWAYS(a_gain_range, clk_i, rst_ni, !out_valid_o || (applied_gain_o <= GAIN_ONE), "applied gain above unity")

  // A configuration request blocks frames in the same cycle.
  `APL_ASSERT_ALWAYS(a_cfg_blocks_frame, clk_i, rst_ni, !cfg_valid_i || in_stall_o, "frame accepted during a configuration request")

  // One frame at a time: the cycle after a request is taken the input stalls.
  `APL_ASSERT_NEXT(a_one_frame, clk_i, rst_ni, in_valid_i && !in_stall_o, in_stall_o, "second frame accepted back to back")

  // A stalled result stays valid, with sample a and the gain unchanged.
  `APL_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o && $stable(out_a_o) && $stable(applied_gain_o), "stalled result changed")

endmodule

bind audio_peak_limiter apl_checker u_apl_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_valid_i),
  .in_stall_o     (in_stall_o),
  .out_valid_o    (out_valid_o),
  .out_stall_i    (out_stall_i),
  .out_a_o        (out_a_o),
  .applied_gain_o (applied_gain_o),
  .cfg_valid_i    (cfg_valid_i)
);
